### sv/extended_euclid_engine_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the extended Euclid engine
// Concurrent checks on clk_i, with and without the reset qualifier.
// ---------------------------------------------------------------------------
`ifndef EXTENDED_EUCLID_ENGINE_CORE_ASSERT_SVH
`define EXTENDED_EUCLID_ENGINE_CORE_ASSERT_SVH

// checked only while out of reset
`define EEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define EEE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/eee_pkg.sv
// ---------------------------------------------------------------------------
// eee_pkg: extended Euclid engine package
// Microcode step codes, jump conditions, datapath operations and the
// read-only control store.
// ---------------------------------------------------------------------------
package eee_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    STEP_IDLE  = 3'd0,
    STEP_CHECK = 3'd1,
    STEP_DIV   = 3'd2,
    STEP_UPD   = 3'd3,
    STEP_FIN   = 3'd4
  } step_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_RC_ZERO,
    COND_DIV_LAST,
    COND_OUT_FREE
  } cond_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_EMIT
  } op_e;

  // hold: stay on this step when the condition is false
  // gate: the operation fires only when the condition is true
  typedef struct packed {
    cond_e cond;
    step_e jmp;
    logic  hold;
    logic  gate;
    op_e   op;
  } ctrl_t;

  function automatic ctrl_t ucode(step_e step);
    ctrl_t w;
    w = '{cond: COND_IN_VALID, jmp: STEP_CHECK, hold: 1'b1, gate: 1'b1, op: OP_LOAD};
    case (step)
      STEP_IDLE:
        w = '{cond: COND_IN_VALID, jmp: STEP_CHECK, hold: 1'b1, gate: 1'b1, op: OP_LOAD};
      STEP_CHECK:
        w = '{cond: COND_RC_ZERO, jmp: STEP_FIN, hold: 1'b0, gate: 1'b0, op: OP_DIV_INIT};
      STEP_DIV:
        w = '{cond: COND_DIV_LAST, jmp: STEP_UPD, hold: 1'b1, gate: 1'b0, op: OP_DIV_STEP};
      STEP_UPD:
        w = '{cond: COND_ALWAYS, jmp: STEP_CHECK, hold: 1'b0, gate: 1'b0, op: OP_UPDATE};
      STEP_FIN:
        w = '{cond: COND_OUT_FREE, jmp: STEP_IDLE, hold: 1'b1, gate: 1'b1, op: OP_EMIT};
      default: ;
    endcase
    return w;
  endfunction

endpackage

### sv/extended_euclid_engine_core.sv
// Throughput: one word at a time; the next word is taken once the result is registered.
// Each step runs on the shared restoring divider, which yields one quotient bit per cycle.
// Reset: rst_ni clears the step counter and output valid; no clearing pass.
// ---------------------------------------------------------------------------
// extended_euclid_engine_core
// Microcoded extended Euclid engine: gcd and Bezout coefficients of two
// signed words, truncating division, DATA_WIDTH+1 bit working precision.
// ---------------------------------------------------------------------------
`include "extended_euclid_engine_core_assert.svh"

module extended_euclid_engine_core #(
  parameter int unsigned DATA_WIDTH = eee_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] first_value_i,
  input  logic signed [DATA_WIDTH-1:0] second_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH:0]   coef_first_o,
  output logic signed [DATA_WIDTH:0]   coef_second_o,
  output logic        [DATA_WIDTH-1:0] divisor_out_o
);

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  eee_pkg::step_e step_q, step_d;
  eee_pkg::ctrl_t ctrl;
  logic           cond_ok;
  logic           fire;
  logic           out_valid_q, out_valid_d;

  logic signed [W:0] rp_q, rc_q, xp_q, xc_q, yp_q, yc_q;
  logic        [W:0] accx_q, accy_q;
  logic [W-1:0]      dvd_q, rem_q, dsr_q;
  logic [CNT_W-1:0]  cnt_q;

  logic signed [W:0] x_out_q, y_out_q;
  logic [W-1:0]      g_out_q;

  logic [W:0]        rp_abs, rc_abs;
  logic [W:0]        part, diff;
  logic              qbit;
  logic [W-1:0]      rem_nx;
  logic [W:0]        accx_nx, accy_nx;
  logic              qneg;
  logic signed [W:0] rem_signed;

  // control store and sequencer
  always_comb begin
    ctrl = eee_pkg::ucode(step_q);
    case (ctrl.cond)
      eee_pkg::COND_ALWAYS:   cond_ok = 1'b1;
      eee_pkg::COND_IN_VALID: cond_ok = in_valid_i;
      eee_pkg::COND_RC_ZERO:  cond_ok = (rc_q == '0);
      eee_pkg::COND_DIV_LAST: cond_ok = (cnt_q == CNT_LAST);
      eee_pkg::COND_OUT_FREE: cond_ok = !out_valid_q || out_ready_i;
      default:                cond_ok = 1'b0;
    endcase
    fire = ctrl.gate ? cond_ok : 1'b1;
    if (cond_ok) begin
      step_d = ctrl.jmp;
    end else if (ctrl.hold) begin
      step_d = step_q;
    end else begin
      step_d = eee_pkg::step_e'(step_q + 3'd1);
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire && ctrl.op == eee_pkg::OP_EMIT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= eee_pkg::STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_comb begin
    rp_abs     = rp_q[W] ? -rp_q : rp_q;
    rc_abs     = rc_q[W] ? -rc_q : rc_q;
    part       = {rem_q, dvd_q[W-1]};
    diff       = part - {1'b0, dsr_q};
    qbit       = !diff[W];
    rem_nx     = qbit ? diff[W-1:0] : part[W-1:0];
    accx_nx    = {accx_q[W-1:0], 1'b0} + (qbit ? xc_q : '0);
    accy_nx    = {accy_q[W-1:0], 1'b0} + (qbit ? yc_q : '0);
    qneg       = rp_q[W] ^ rc_q[W];
    rem_signed = rp_q[W] ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      case (ctrl.op)
        eee_pkg::OP_LOAD: begin
          rp_q <= (W+1)'(first_value_i);
          rc_q <= (W+1)'(second_value_i);
          xp_q <= (W+1)'(1);
          xc_q <= '0;
          yp_q <= '0;
          yc_q <= (W+1)'(1);
        end
        eee_pkg::OP_DIV_INIT: begin
          dvd_q  <= rp_abs[W-1:0];
          dsr_q  <= rc_abs[W-1:0];
          rem_q  <= '0;
          accx_q <= '0;
          accy_q <= '0;
          cnt_q  <= '0;
        end
        eee_pkg::OP_DIV_STEP: begin
          rem_q  <= rem_nx;
          dvd_q  <= {dvd_q[W-2:0], qbit};
          accx_q <= accx_nx;
          accy_q <= accy_nx;
          cnt_q  <= cnt_q + 1'b1;
        end
        eee_pkg::OP_UPDATE: begin
          rp_q <= rc_q;
          rc_q <= rem_signed;
          xp_q <= xc_q;
          yp_q <= yc_q;
          xc_q <= qneg ? xp_q + $signed(accx_q) : xp_q - $signed(accx_q);
          yc_q <= qneg ? yp_q + $signed(accy_q) : yp_q - $signed(accy_q);
        end
        eee_pkg::OP_EMIT: begin
          x_out_q <= rp_q[W] ? -xp_q : xp_q;
          y_out_q <= rp_q[W] ? -yp_q : yp_q;
          g_out_q <= rp_abs[W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign in_ready_o    = (step_q == eee_pkg::STEP_IDLE);
  assign out_valid_o   = out_valid_q;
  assign coef_first_o  = x_out_q;
  assign coef_second_o = y_out_q;
  assign divisor_out_o = g_out_q;

  `EEE_ASSERT(a_div_nonzero, (step_q == eee_pkg::STEP_DIV) |-> (rc_q != '0), "divide by zero")
  `EEE_ASSERT(a_accept_busy, (in_valid_i && in_ready_o) |=> !in_ready_o, "accept while busy")
  `EEE_ASSERT(a_emit_valid, (step_q == eee_pkg::STEP_FIN && (!out_valid_q || out_ready_i)) |=> out_valid_o, "result lost")
  `EEE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!out_valid_o && in_ready_o), "reset state")

endmodule
